// ----- rtl/proportional_bitmap_text_renderer_defines.svh -----
// Assertion macros for the proportional bitmap text renderer.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef PROPORTIONAL_BITMAP_TEXT_RENDERER_DEFINES_SVH
`define PROPORTIONAL_BITMAP_TEXT_RENDERER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define PBTR_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pbtr: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent
`define PBTR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pbtr: next-cycle check failed");

`endif

// ----- rtl/pbtr_pkg.sv -----
// Shared types and constants of the proportional bitmap text renderer.
// No dependencies; used by pbtr_ctrl, pbtr_datapath and the top level.
`default_nettype none

package pbtr_pkg;

  // Default sizes
  localparam int unsigned FontBytesDef = 16384;
  localparam int unsigned MaxRowsDef   = 32;

  // Glyph bitmap starts at this font byte
  localparam int unsigned BitmapBase = 8;

  // Configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_FIRST_CHAR   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_GLYPH_HEIGHT = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ROW_STRIDE   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_TABLE_OFFSET = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_TEXT_COLOR   = 3'd4;

  // Request codes
  localparam logic [1:0] REQ_WRITE   = 2'd0;
  localparam logic [1:0] REQ_PEN     = 2'd1;
  localparam logic [1:0] REQ_DRAW    = 2'd2;
  localparam logic [1:0] REQ_MEASURE = 2'd3;

  // Font memory read address select
  typedef enum logic [2:0] {
    RD_TAB_HI,
    RD_TAB_LO,
    RD_ROW0,
    RD_ROW1,
    RD_ROW2
  } rd_sel_e;

  // Controller to datapath commands
  typedef struct packed {
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    cap_hi;
    logic    cap_b0;
    logic    cap_b1;
    logic    load_glyph;
    logic    emit_row;
    logic    emit_space;
    logic    emit_meas;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
    logic is_measure;
    logic glyph_space;
    logic last_row;
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/pbtr_ctrl.sv -----
// Sequencer of the proportional bitmap text renderer.
// Depends on pbtr_pkg for the command and status structs.
`default_nettype none

module pbtr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [1:0]         req_type_i,
  output logic               in_ready_o,
  input  pbtr_pkg::sts_t     sts_i,
  output pbtr_pkg::cmd_t     cmd_o
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_ENT0  = 4'd1;
  localparam logic [3:0] ST_ENT1  = 4'd2;
  localparam logic [3:0] ST_ENT2  = 4'd3;
  localparam logic [3:0] ST_MEAS  = 4'd4;
  localparam logic [3:0] ST_SPACE = 4'd5;
  localparam logic [3:0] ST_RD0   = 4'd6;
  localparam logic [3:0] ST_RD1   = 4'd7;
  localparam logic [3:0] ST_RD2   = 4'd8;
  localparam logic [3:0] ST_EMIT  = 4'd9;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  // Next state and command decode
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (req_type_i == pbtr_pkg::REQ_DRAW ||
                           req_type_i == pbtr_pkg::REQ_MEASURE)) begin
          state_d = ST_ENT0;
        end
      end
      ST_ENT0: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = pbtr_pkg::RD_TAB_HI;
        state_d      = ST_ENT1;
      end
      ST_ENT1: begin
        cmd_o.cap_hi = 1'b1;
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = pbtr_pkg::RD_TAB_LO;
        state_d      = ST_ENT2;
      end
      ST_ENT2: begin
        cmd_o.load_glyph = 1'b1;
        if (sts_i.is_measure) begin
          state_d = ST_MEAS;
        end else if (sts_i.glyph_space) begin
          state_d = ST_SPACE;
        end else begin
          state_d = ST_RD0;
        end
      end
      ST_MEAS: begin
        if (sts_i.out_free) begin
          cmd_o.emit_meas = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      ST_SPACE: begin
        if (sts_i.out_free) begin
          cmd_o.emit_space = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      ST_RD0: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = pbtr_pkg::RD_ROW0;
        state_d      = ST_RD1;
      end
      ST_RD1: begin
        cmd_o.cap_b0 = 1'b1;
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = pbtr_pkg::RD_ROW1;
        state_d      = ST_RD2;
      end
      ST_RD2: begin
        cmd_o.cap_b1 = 1'b1;
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = pbtr_pkg::RD_ROW2;
        state_d      = ST_EMIT;
      end
      ST_EMIT: begin
        // Third byte sits in the read register until the row is taken
        if (sts_i.out_free) begin
          cmd_o.emit_row = 1'b1;
          state_d        = sts_i.last_row ? ST_IDLE : ST_RD0;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pbtr_datapath.sv -----
// Datapath of the proportional bitmap text renderer: font memory, settings,
// pen and width registers, row mask build and output register. Uses pbtr_pkg.
`default_nettype none

module pbtr_datapath #(
  parameter int unsigned FONT_BYTES = pbtr_pkg::FontBytesDef,
  parameter int unsigned MAX_ROWS   = pbtr_pkg::MaxRowsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_valid_i,
  input  logic [pbtr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pbtr_pkg::CfgDataW-1:0] cfg_data_i,
  // accepted request
  input  logic                          in_accept_i,
  input  logic [1:0]                    req_type_i,
  input  logic [13:0]                   mem_addr_i,
  input  logic [7:0]                    mem_data_i,
  input  logic signed [15:0]            pen_x_in_i,
  input  logic signed [15:0]            pen_y_in_i,
  input  logic [7:0]                    char_code_i,
  // control
  input  pbtr_pkg::cmd_t                cmd_i,
  output pbtr_pkg::sts_t                sts_o,
  // result
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [15:0]            out_x_o,
  output logic signed [15:0]            out_y_o,
  output logic [14:0]                   row_mask_o,
  output logic [7:0]                    pixel_color_o,
  output logic [15:0]                   run_width_o,
  output logic                          last_o
);

  localparam int unsigned AW   = $clog2(FONT_BYTES);
  localparam int unsigned CntW = $clog2(MAX_ROWS + 1);
  // wide enough for any address sum before wrapping to AW bits
  localparam int unsigned ExtW = 17;

  // Settings
  logic [7:0]  first_char_q;
  logic [5:0]  glyph_height_q;
  logic [13:0] row_stride_q;
  logic [13:0] table_offset_q;
  logic [7:0]  text_color_q;

  // Pen and measure state
  logic [15:0] pen_x_q, pen_y_q, width_total_q;

  // Request and glyph registers
  logic [1:0]      req_q;
  logic [7:0]      code_q;
  logic [7:0]      hi_q, b0_q, b1_q, rd_q;
  logic [3:0]      w_q;
  logic [2:0]      sub_q;
  logic [AW-1:0]   row_addr_q;
  logic [CntW-1:0] row_cnt_q;

  // Output register
  logic        out_valid_q;
  logic [15:0] out_x_q, out_y_q, run_q;
  logic [14:0] mask_q;
  logic [7:0]  color_q;
  logic        last_q;

  logic [7:0] font_mem_q [FONT_BYTES];

  // Settings writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_char_q   <= 8'd0;
      glyph_height_q <= 6'd8;
      row_stride_q   <= 14'd1;
      table_offset_q <= 14'd0;
      text_color_q   <= 8'd15;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        pbtr_pkg::CFG_FIRST_CHAR:   first_char_q   <= cfg_data_i[7:0];
        pbtr_pkg::CFG_GLYPH_HEIGHT: glyph_height_q <= cfg_data_i[5:0];
        pbtr_pkg::CFG_ROW_STRIDE:   row_stride_q   <= cfg_data_i[13:0];
        pbtr_pkg::CFG_TABLE_OFFSET: table_offset_q <= cfg_data_i[13:0];
        pbtr_pkg::CFG_TEXT_COLOR:   text_color_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Table entry address: signed index times two, wrapped to the memory
  logic signed [8:0] tab_idx;
  logic [ExtW-1:0]   tab_sum;
  logic [AW-1:0]     tab_addr;
  assign tab_idx  = $signed({1'b0, code_q}) - $signed({1'b0, first_char_q});
  assign tab_sum  = ExtW'(table_offset_q) + {{(ExtW-10){tab_idx[8]}}, tab_idx, 1'b0};
  assign tab_addr = tab_sum[AW-1:0];

  // Write address, stride and first row address wrapped to the memory
  logic [ExtW-1:0] wr_ext, stride_ext, row0_ext;
  assign wr_ext     = ExtW'(mem_addr_i);
  assign stride_ext = ExtW'(row_stride_q);
  assign row0_ext   = ExtW'(pbtr_pkg::BitmapBase) + ExtW'({hi_q[3:0], rd_q[7:3]});

  logic [AW-1:0] rd_addr;
  always_comb begin
    unique case (cmd_i.rd_sel)
      pbtr_pkg::RD_TAB_HI: rd_addr = tab_addr;
      pbtr_pkg::RD_TAB_LO: rd_addr = tab_addr + AW'(1);
      pbtr_pkg::RD_ROW0:   rd_addr = row_addr_q;
      pbtr_pkg::RD_ROW1:   rd_addr = row_addr_q + AW'(1);
      pbtr_pkg::RD_ROW2:   rd_addr = row_addr_q + AW'(2);
      default:             rd_addr = '0;
    endcase
  end

  // Font memory: write on an accepted write word, registered read
  always_ff @(posedge clk_i) begin
    if (in_accept_i && req_type_i == pbtr_pkg::REQ_WRITE) begin
      font_mem_q[wr_ext[AW-1:0]] <= mem_data_i;
    end
    if (cmd_i.rd_en) begin
      rd_q <= font_mem_q[rd_addr];
    end
  end

  // Rows per glyph: zero counts as one, clamp to the bound
  logic [6:0]      rows_full;
  logic [CntW-1:0] rows_eff;
  logic [CntW-1:0] row_cnt_nxt;
  always_comb begin
    if (glyph_height_q == 6'd0) begin
      rows_full = 7'd1;
    end else if ({1'b0, glyph_height_q} > 7'(MAX_ROWS)) begin
      rows_full = 7'(MAX_ROWS);
    end else begin
      rows_full = {1'b0, glyph_height_q};
    end
  end
  assign rows_eff    = rows_full[CntW-1:0];
  assign row_cnt_nxt = row_cnt_q + CntW'(1);

  // Build the row mask: pixel i is bit (sub+i) of the three bytes, MSB first
  logic [23:0] win_sh;
  logic [14:0] mask_row;
  assign win_sh = {b0_q, b1_q, rd_q} << sub_q;
  always_comb begin
    for (int i = 0; i < 15; i++) begin
      mask_row[i] = win_sh[23-i] && (4'(i) < w_q);
    end
  end

  // Advance used by measure
  logic [15:0] meas_adv;
  assign meas_adv = (w_q == 4'd0) ? 16'd3 : 16'(w_q) + 16'd1;

  // Capture request and glyph state
  always_ff @(posedge clk_i) begin
    if (in_accept_i) begin
      req_q  <= req_type_i;
      code_q <= char_code_i;
    end
    if (cmd_i.cap_hi) hi_q <= rd_q;
    if (cmd_i.cap_b0) b0_q <= rd_q;
    if (cmd_i.cap_b1) b1_q <= rd_q;
    if (cmd_i.load_glyph) begin
      w_q        <= hi_q[7:4];
      sub_q      <= rd_q[2:0];
      row_addr_q <= row0_ext[AW-1:0];
    end else if (cmd_i.emit_row) begin
      row_addr_q <= row_addr_q + stride_ext[AW-1:0];
    end
  end

  // Row counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q <= '0;
    end else if (cmd_i.load_glyph) begin
      row_cnt_q <= '0;
    end else if (cmd_i.emit_row) begin
      row_cnt_q <= row_cnt_nxt;
    end
  end

  // Pen and running width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_x_q       <= 16'd0;
      pen_y_q       <= 16'd0;
      width_total_q <= 16'd0;
    end else begin
      if (in_accept_i && req_type_i == pbtr_pkg::REQ_PEN) begin
        pen_x_q       <= pen_x_in_i;
        pen_y_q       <= pen_y_in_i;
        width_total_q <= 16'd0;
      end
      if (cmd_i.emit_space) begin
        pen_x_q <= pen_x_q + 16'd3;
      end
      if (cmd_i.emit_row && row_cnt_nxt == rows_eff) begin
        pen_x_q <= pen_x_q + 16'(w_q) + 16'd1;
      end
      if (cmd_i.emit_meas) begin
        width_total_q <= width_total_q + meas_adv;
      end
    end
  end

  // Output valid: set on emit, drop when taken
  logic emit_any;
  assign emit_any = cmd_i.emit_row || cmd_i.emit_space || cmd_i.emit_meas;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_any) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output word
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_row) begin
      out_x_q <= pen_x_q;
      out_y_q <= pen_y_q + 16'(row_cnt_q);
      mask_q  <= mask_row;
      color_q <= text_color_q;
      run_q   <= 16'd0;
      last_q  <= (row_cnt_nxt == rows_eff);
    end else if (cmd_i.emit_space) begin
      out_x_q <= pen_x_q;
      out_y_q <= pen_y_q;
      mask_q  <= 15'd0;
      color_q <= text_color_q;
      run_q   <= 16'd0;
      last_q  <= 1'b1;
    end else if (cmd_i.emit_meas) begin
      out_x_q <= 16'd0;
      out_y_q <= 16'd0;
      mask_q  <= 15'd0;
      color_q <= 8'd0;
      run_q   <= width_total_q + meas_adv;
      last_q  <= 1'b1;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_x_o       = $signed(out_x_q);
  assign out_y_o       = $signed(out_y_q);
  assign row_mask_o    = mask_q;
  assign pixel_color_o = color_q;
  assign run_width_o   = run_q;
  assign last_o        = last_q;

  // Status to the sequencer
  assign sts_o.out_free    = !out_valid_q || out_ready_i;
  assign sts_o.is_measure  = (req_q == pbtr_pkg::REQ_MEASURE);
  assign sts_o.glyph_space = (hi_q[7:4] == 4'd0);
  assign sts_o.last_row    = (row_cnt_nxt == rows_eff);

endmodule

`default_nettype wire

// ----- rtl/proportional_bitmap_text_renderer.sv -----
// Top level of the proportional bitmap text renderer: sequencer plus datapath.
// Depends on pbtr_pkg, pbtr_ctrl, pbtr_datapath and the assertion macro header.
`default_nettype none
`include "proportional_bitmap_text_renderer_defines.svh"

// Renders proportional 1bpp glyphs held in an on-chip font memory of
// FONT_BYTES bytes (a power of two; every font address wraps to it). A write
// word or a set-pen word is done as soon as it is taken and gives no result.
// Draw and measure words fetch the two-byte glyph entry, high byte first,
// through the single read port of the font memory. A measure or a space
// glyph then gives its one result. A visible glyph gives one row word per
// glyph row, its three bitmap bytes coming one by one through that same read
// port. Each result waits until the output register is free, so a stall on
// the output side holds the block. Results leave through an output register.
// Settings are written on the cfg port, which is always ready; write them
// only while the block is idle.
module proportional_bitmap_text_renderer #(
  parameter int unsigned FONT_BYTES = pbtr_pkg::FontBytesDef,
  parameter int unsigned MAX_ROWS   = pbtr_pkg::MaxRowsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pbtr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pbtr_pkg::CfgDataW-1:0] cfg_data_i,
  // request
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    req_type_i,
  input  logic [13:0]                   mem_addr_i,
  input  logic [7:0]                    mem_data_i,
  input  logic signed [15:0]            pen_x_in_i,
  input  logic signed [15:0]            pen_y_in_i,
  input  logic [7:0]                    char_code_i,
  // result
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [15:0]            out_x_o,
  output logic signed [15:0]            out_y_o,
  output logic [14:0]                   row_mask_o,
  output logic [7:0]                    pixel_color_o,
  output logic [15:0]                   run_width_o,
  output logic                          last_o
);

  pbtr_pkg::cmd_t cmd;
  pbtr_pkg::sts_t sts;
  logic           in_accept;

  assign cfg_ready_o = 1'b1;
  assign in_accept   = in_valid_i && in_ready_o;

  pbtr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pbtr_datapath #(
    .FONT_BYTES (FONT_BYTES),
    .MAX_ROWS   (MAX_ROWS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_accept_i   (in_accept),
    .req_type_i    (req_type_i),
    .mem_addr_i    (mem_addr_i),
    .mem_data_i    (mem_data_i),
    .pen_x_in_i    (pen_x_in_i),
    .pen_y_in_i    (pen_y_in_i),
    .char_code_i   (char_code_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_x_o       (out_x_o),
    .out_y_o       (out_y_o),
    .row_mask_o    (row_mask_o),
    .pixel_color_o (pixel_color_o),
    .run_width_o   (run_width_o),
    .last_o        (last_o)
  );

  // A draw or measure word holds off the next word while it runs
  `PBTR_ASSERT_NEXT(a_busy_after_glyph, in_accept && req_type_i[1], !in_ready_o)
  // Write and set-pen words finish in the cycle they are taken
  `PBTR_ASSERT_NEXT(a_idle_after_simple, in_accept && !req_type_i[1], in_ready_o)
  // Only the closing word of an item can carry a running width
  `PBTR_ASSERT_IMPLY(a_run_only_last, out_valid_o && run_width_o != 16'd0,
                     last_o && row_mask_o == 15'd0)

endmodule

`default_nettype wire

// ----- tb/proportional_bitmap_text_renderer_checker.sv -----
// Checker for the proportional bitmap text renderer: watches the settings, request and
// row word channels, predicts every row word and compares it field by field.
// Depends on pbtr_pkg for the request and register codes.
module proportional_bitmap_text_renderer_checker #(
  parameter int unsigned FONT_BYTES = pbtr_pkg::FontBytesDef,
  parameter int unsigned MAX_ROWS   = pbtr_pkg::MaxRowsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [pbtr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pbtr_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [1:0]                    req_type_i,
  input  logic [13:0]                   mem_addr_i,
  input  logic [7:0]                    mem_data_i,
  input  logic [15:0]                   pen_x_in_i,
  input  logic [15:0]                   pen_y_in_i,
  input  logic [7:0]                    char_code_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [15:0]                   out_x_i,
  input  logic [15:0]                   out_y_i,
  input  logic [14:0]                   row_mask_i,
  input  logic [7:0]                    pixel_color_i,
  input  logic [15:0]                   run_width_i,
  input  logic                          last_i,
  output int unsigned                   mismatch_count_o,
  output int unsigned                   outstanding_o
);
  import pbtr_pkg::*;

  localparam int FontSize = int'(FONT_BYTES);
  localparam int RowLimit = int'(MAX_ROWS);

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [14:0] mask;
    logic [7:0]  color;
    logic [15:0] width;
    logic        last;
  } row_word_t;

  // Shadow of the font store, the pen and the settings
  logic [7:0]  font_copy [FONT_BYTES];
  logic [15:0] pen_col;
  logic [15:0] pen_row;
  logic [15:0] text_width;
  logic [7:0]  base_code;
  logic [5:0]  rows_cfg;
  logic [13:0] stride;
  logic [13:0] table_base;
  logic [7:0]  ink;

  row_word_t   rows_due [$];
  row_word_t   due;

  task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
    $display("checker: %0t: %s mismatch, got %h, want %h", $time, field, got, want);
    mismatch_count_o++;
  endtask

  // Wrap any font address, negative ones too, into the store
  function automatic logic [7:0] font_at(int addr);
    int wrapped;
    wrapped = addr % FontSize;
    if (wrapped < 0) wrapped += FontSize;
    return font_copy[wrapped];
  endfunction

  // Big-endian glyph entry; the index below the first code is negative
  function automatic logic [15:0] glyph_entry_of(logic [7:0] code);
    int slot;
    slot = int'(table_base) + (int'(code) - int'(base_code)) * 2;
    return {font_at(slot), font_at(slot + 1)};
  endfunction

  // Apply one request word to the shadow state and queue the rows it gives
  task automatic predict_word(logic [1:0] req, logic [13:0] addr, logic [7:0] data,
                              logic [15:0] px, logic [15:0] py, logic [7:0] code);
    logic [15:0] entry;
    logic [3:0]  w;
    logic [14:0] mask;
    logic [7:0]  b;
    row_word_t   word;
    int          rows;
    int          base;
    int          sub;
    int          pos;
    entry = '0;
    w     = '0;
    if (req == REQ_DRAW || req == REQ_MEASURE) begin
      entry = glyph_entry_of(code);
      w     = entry[15:12];
    end
    word = '0;
    case (req)
      REQ_WRITE: font_copy[int'(addr) % FontSize] = data;
      REQ_PEN: begin
        pen_col    = px;
        pen_row    = py;
        text_width = '0;
      end
      REQ_MEASURE: begin
        // a space measures as width three
        text_width = text_width + ((w == 4'd0) ? 16'd3 : 16'(w) + 16'd1);
        word.width = text_width;
        word.last  = 1'b1;
        rows_due.push_back(word);
      end
      default: begin
        if (w == 4'd0) begin
          // space: one empty row word, pen moves on by three
          word.x     = pen_col;
          word.y     = pen_row;
          word.color = ink;
          word.last  = 1'b1;
          rows_due.push_back(word);
          pen_col = pen_col + 16'd3;
        end else begin
          rows = (rows_cfg == 6'd0) ? 1 :
                 ((int'(rows_cfg) > RowLimit) ? RowLimit : int'(rows_cfg));
          sub  = int'(entry[2:0]);
          base = int'(BitmapBase) + int'(entry[11:3]);
          for (int r = 0; r < rows; r++) begin
            mask = '0;
            for (int i = 0; i < int'(w); i++) begin
              pos     = sub + i;
              b       = font_at(base + pos / 8);
              mask[i] = b[7 - pos % 8];
            end
            word       = '0;
            word.x     = pen_col;
            word.y     = pen_row + 16'(r);
            word.mask  = mask;
            word.color = ink;
            word.last  = (r == rows - 1);
            rows_due.push_back(word);
            base += int'(stride);
          end
          pen_col = pen_col + 16'(w) + 16'd1;
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_col    = '0;
      pen_row    = '0;
      text_width = '0;
      base_code  = 8'd0;
      rows_cfg   = 6'd8;
      stride     = 14'd1;
      table_base = 14'd0;
      ink        = 8'd15;
      rows_due.delete();
      outstanding_o <= 0;
    end else begin
      // take settings words
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_FIRST_CHAR:   base_code  = cfg_data_i[7:0];
          CFG_GLYPH_HEIGHT: rows_cfg   = cfg_data_i[5:0];
          CFG_ROW_STRIDE:   stride     = cfg_data_i[13:0];
          CFG_TABLE_OFFSET: table_base = cfg_data_i[13:0];
          CFG_TEXT_COLOR:   ink        = cfg_data_i[7:0];
          default: ;
        endcase
      end
      // compare each row word with the oldest one due
      if (out_valid_i && out_ready_i) begin
        if (rows_due.size() == 0) begin
          report_mismatch("unexpected row word, out_x", out_x_i, 16'd0);
        end else begin
          due = rows_due.pop_front();
          if (out_x_i !== due.x) report_mismatch("out_x", out_x_i, due.x);
          if (out_y_i !== due.y) report_mismatch("out_y", out_y_i, due.y);
          if (row_mask_i !== due.mask)
            report_mismatch("row_mask", 16'(row_mask_i), 16'(due.mask));
          if (pixel_color_i !== due.color)
            report_mismatch("pixel_color", 16'(pixel_color_i), 16'(due.color));
          if (run_width_i !== due.width)
            report_mismatch("run_width", run_width_i, due.width);
          if (last_i !== due.last) report_mismatch("last", 16'(last_i), 16'(due.last));
        end
      end
      // predict from each accepted request word
      if (in_valid_i && in_ready_i)
        predict_word(req_type_i, mem_addr_i, mem_data_i, pen_x_in_i, pen_y_in_i, char_code_i);
      outstanding_o <= rows_due.size();
    end
  end

endmodule

// ----- tb/proportional_bitmap_text_renderer_tb.sv -----
// Testbench top for the proportional bitmap text renderer: clock, reset, stimulus and verdict.
// Depends on pbtr_pkg, the renderer RTL and proportional_bitmap_text_renderer_checker.
module proportional_bitmap_text_renderer_tb;
  import pbtr_pkg::*;

  localparam int FontSize = int'(FontBytesDef);

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [1:0]          req_type_i;
  logic [13:0]         mem_addr_i;
  logic [7:0]          mem_data_i;
  logic signed [15:0]  pen_x_in_i;
  logic signed [15:0]  pen_y_in_i;
  logic [7:0]          char_code_i;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic signed [15:0]  out_x_o;
  logic signed [15:0]  out_y_o;
  logic [14:0]         row_mask_o;
  logic [7:0]          pixel_color_o;
  logic [15:0]         run_width_o;
  logic                last_o;

  int unsigned         mismatches;
  int unsigned         outstanding;
  bit                  calm;

  // Stimulus-side image of the font store and settings, for address planning
  logic [7:0]          font_img [FontSize];
  bit                  font_set [FontSize];
  logic [7:0]          first_code;
  logic [5:0]          height_cfg;
  logic [13:0]         stride_cfg;
  logic [13:0]         table_cfg;

  always #2 clk_i = ~clk_i;

  proportional_bitmap_text_renderer u_dut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .req_type_i, .mem_addr_i, .mem_data_i,
    .pen_x_in_i, .pen_y_in_i, .char_code_i,
    .out_valid_o, .out_ready_i, .out_x_o, .out_y_o, .row_mask_o,
    .pixel_color_o, .run_width_o, .last_o
  );

  proportional_bitmap_text_renderer_checker u_checker (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i (cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i (in_ready_o), .req_type_i, .mem_addr_i, .mem_data_i,
    .pen_x_in_i, .pen_y_in_i, .char_code_i,
    .out_valid_i (out_valid_o), .out_ready_i, .out_x_i (out_x_o), .out_y_i (out_y_o),
    .row_mask_i (row_mask_o), .pixel_color_i (pixel_color_o),
    .run_width_i (run_width_o), .last_i (last_o),
    .mismatch_count_o (mismatches), .outstanding_o (outstanding)
  );

  // Stall the row word side at random, except in calm stretches
  always @(posedge clk_i) out_ready_i <= calm || ($urandom_range(99) >= 34);

  function automatic int wrap_addr(int a);
    int w;
    w = a % FontSize;
    if (w < 0) w += FontSize;
    return w;
  endfunction

  function automatic int slot_of(logic [7:0] code);
    return wrap_addr(int'(table_cfg) + (int'(code) - int'(first_code)) * 2);
  endfunction

  // Present one request word, idling first at random, and hold it until taken
  task automatic send_word(logic [1:0] req, logic [13:0] addr, logic [7:0] data,
                           logic [15:0] px, logic [15:0] py, logic [7:0] code);
    while (!calm && $urandom_range(99) < 34) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= req;
    mem_addr_i  <= addr;
    mem_data_i  <= data;
    pen_x_in_i  <= px;
    pen_y_in_i  <= py;
    char_code_i <= code;
    do @(posedge clk_i); while (!in_ready_o);
    if (req == REQ_WRITE) begin
      font_img[addr] = data;
      font_set[addr] = 1'b1;
    end
  endtask

  task automatic write_byte(int a, logic [7:0] d);
    send_word(REQ_WRITE, 14'(wrap_addr(a)), d, 16'($urandom), 16'($urandom), 8'($urandom));
  endtask

  // Give a never-written byte random content before anything reads it
  task automatic fill_byte(int a);
    int w;
    w = wrap_addr(a);
    if (!font_set[w]) write_byte(w, 8'($urandom));
  endtask

  task automatic define_glyph(logic [7:0] code, logic [3:0] w, logic [11:0] bits);
    int slot;
    slot = slot_of(code);
    write_byte(slot, {w, bits[11:8]});
    write_byte(slot + 1, bits[7:0]);
  endtask

  // Make sure the table entry and, for a draw, every bitmap byte it reaches are written
  task automatic prepare_glyph(logic [7:0] code, bit for_draw);
    int          slot;
    int          base;
    int          rows;
    logic [15:0] entry;
    slot = slot_of(code);
    fill_byte(slot);
    fill_byte(slot + 1);
    if (for_draw) begin
      entry = {font_img[slot], font_img[wrap_addr(slot + 1)]};
      if (entry[15:12] != 4'd0) begin
        rows = (height_cfg == 6'd0) ? 1 :
               ((int'(height_cfg) > int'(MaxRowsDef)) ? int'(MaxRowsDef) : int'(height_cfg));
        base = int'(BitmapBase) + int'(entry[11:3]);
        for (int r = 0; r < rows; r++)
          for (int k = 0; k < 3; k++)
            fill_byte(base + r * int'(stride_cfg) + k);
      end
    end
  endtask

  task automatic draw_char(logic [7:0] code);
    prepare_glyph(code, 1'b1);
    send_word(REQ_DRAW, 14'($urandom), 8'($urandom), 16'($urandom), 16'($urandom), code);
  endtask

  task automatic measure_char(logic [7:0] code);
    prepare_glyph(code, 1'b0);
    send_word(REQ_MEASURE, 14'($urandom), 8'($urandom), 16'($urandom), 16'($urandom), code);
  endtask

  task automatic place_pen(logic [15:0] x, logic [15:0] y);
    send_word(REQ_PEN, 14'($urandom), 8'($urandom), x, y, 8'($urandom));
  endtask

  // Hold off until every row word is in, then let a write finish inside the block
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic configure(logic [7:0] fc, logic [5:0] gh, logic [13:0] rs,
                           logic [13:0] tof, logic [7:0] tc);
    drain();
    write_reg(CFG_FIRST_CHAR, 16'(fc));
    write_reg(CFG_GLYPH_HEIGHT, 16'(gh));
    write_reg(CFG_ROW_STRIDE, 16'(rs));
    write_reg(CFG_TABLE_OFFSET, 16'(tof));
    write_reg(CFG_TEXT_COLOR, 16'(tc));
    cfg_valid_i <= 1'b0;
    first_code = fc;
    height_cfg = gh;
    stride_cfg = rs;
    table_cfg  = tof;
  endtask

  // Mostly short glyphs and small strides, now and then the full range
  task automatic random_settings();
    logic [5:0]  gh;
    logic [13:0] rs;
    gh = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(1, 8));
    rs = ($urandom_range(3) == 0) ? 14'($urandom) : 14'($urandom_range(0, 40));
    configure(8'($urandom), gh, rs, 14'($urandom), 8'($urandom));
  endtask

  task automatic random_run(int ops);
    logic [7:0] code;
    int         pick;
    repeat (ops) begin
      pick = $urandom_range(99);
      code = 8'($urandom);
      if (pick < 40) draw_char(code);
      else if (pick < 55) measure_char(code);
      else if (pick < 65) place_pen(16'($urandom), 16'($urandom));
      else if (pick < 75)
        define_glyph(code, ($urandom_range(3) == 0) ? 4'd0 : 4'($urandom), 12'($urandom));
      else if (pick < 85) write_byte(int'($urandom_range(FontSize - 1)), 8'($urandom));
      else if (pick < 90) drain();
      else draw_char(first_code + 8'($urandom_range(2)) - 8'd1);
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    calm        = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_FIRST_CHAR;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    req_type_i  = REQ_WRITE;
    mem_addr_i  = '0;
    mem_data_i  = '0;
    pen_x_in_i  = '0;
    pen_y_in_i  = '0;
    char_code_i = '0;
    first_code  = 8'd0;
    height_cfg  = 6'd8;
    stride_cfg  = 14'd1;
    table_cfg   = 14'd0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // widest glyph at the last sub-byte offset, space, narrowest glyph
    place_pen(16'h0000, 16'h0000);
    define_glyph(8'h41, 4'hf, 12'hfff);
    draw_char(8'h41);
    define_glyph(8'h20, 4'h0, 12'h5a5);
    draw_char(8'h20);
    measure_char(8'h20);
    measure_char(8'h41);
    define_glyph(8'h01, 4'h1, 12'h000);
    draw_char(8'h01);
    // pen wraps in x and rows wrap in y
    place_pen(16'h7fff, 16'h7ffc);
    draw_char(8'h41);
    place_pen(16'h8000, 16'h8000);
    draw_char(8'hff);
    draw_char(8'h00);
    write_byte(FontSize - 1, 8'hff);
    measure_char(8'hff);

    // codes below the first entry, zero height and stride, table round the top
    configure(8'hff, 6'd0, 14'd0, 14'h3fff, 8'h00);
    draw_char(8'h00);
    draw_char(8'hff);
    measure_char(8'hfe);
    // height above the row limit, widest stride
    configure(8'h80, 6'd63, 14'h3fff, 14'h1234, 8'hff);
    draw_char(8'h80);
    draw_char(8'h7f);
    configure(8'h00, 6'd32, 14'd1, 14'd0, 8'h0f);
    draw_char(8'h41);

    // random phases, one of them without idling
    for (int p = 0; p < 3; p++) begin
      random_settings();
      calm <= (p == 1);
      random_run(5);
    end
    calm <= 1'b0;

    drain();
    if (mismatches == 0)
      $display("proportional_bitmap_text_renderer_tb: PASS");
    else
      $display("proportional_bitmap_text_renderer_tb: FAIL");
    $finish;
  end

  // Stop a hung run
  initial begin
    #2000000;
    $display("proportional_bitmap_text_renderer_tb: FAIL");
    $finish;
  end

endmodule
